[hdl/ant_pkg.sv]
// Package for the aging node table: sizes, command and status codes, FSM states.
// No dependencies.
`default_nettype none
package ant_pkg;
  localparam int MaxRecords   = 16;
  localparam int MaxNeighbors = 16;
  localparam int RecW  = $clog2(MaxRecords);
  localparam int NbrW  = $clog2(MaxNeighbors);
  localparam int CntW  = $clog2(MaxRecords + 1);
  localparam int NcW   = $clog2(MaxNeighbors + 1);
  localparam int NbrAw = RecW + NbrW;

  localparam logic [1:0] CmdUpsert = 2'd0;
  localparam logic [1:0] CmdWrite  = 2'd1;
  localparam logic [1:0] CmdExpire = 2'd2;
  localparam logic [1:0] CmdRead   = 2'd3;

  localparam logic [2:0] StUpdated  = 3'd0;
  localparam logic [2:0] StInserted = 3'd1;
  localparam logic [2:0] StFull     = 3'd2;
  localparam logic [2:0] StBadIndex = 3'd3;
  localparam logic [2:0] StDone     = 3'd4;

  typedef enum logic [3:0] {
    S_IDLE, S_SEARCH, S_APPEND, S_CLEAR, S_SCAN, S_MOVE, S_READ, S_READ2, S_REPLY
  } state_e;

  // Controller to datapath commands.
  typedef struct packed {
    logic latch;      // capture the request
    logic idx_clr;    // clear walk index, kept count, nbr index
    logic idx_inc;    // advance the walk index
    logic nbr_inc;    // advance the neighbor index
    logic rd_meta;    // read record fields at walk index (or entry index)
    logic rd_sel_e;   // use entry index as read address
    logic wr_meta_new;// write vertex/count/stamp at target
    logic wr_nbr_clr; // clear neighbor at (target, nbr index)
    logic wr_nbr_req; // write neighbor of request
    logic mv_meta;    // copy meta from walk index to kept
    logic mv_nbr;     // copy read neighbor into kept row
    logic keep;       // record at walk index survives
    logic drop;       // record at walk index expires
    logic set_hit;    // upsert target is walk index minus one
    logic set_app;    // upsert target is append position
    logic fin_up;     // finish upsert
    logic fin_full;   // finish upsert on full table
    logic fin_exp;    // finish expire
    logic capture;    // capture read outputs
    logic emit;       // present result
  } ctl_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic walk_end;   // walk index reached used count
    logic hit;        // vertex match on the record read last cycle
    logic full;
    logic expired;    // expiry test at walk index
    logic moving;     // kept differs from walk index
    logic nbr_last;   // neighbor index at last slot
    logic wr_ok;
    logic rd_ok;
  } sts_t;
endpackage
`default_nettype wire

[hdl/ant_ram.sv]
// Generic single-port-write, one-read RAM with registered read data.
// No dependencies.
`default_nettype none
module ant_ram #(
  parameter int Width = 16,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

[hdl/ant_ctrl.sv]
// Controller state machine of the aging node table.
// Depends on ant_pkg.
`default_nettype none
module ant_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  output logic               busy,
  input  wire ant_pkg::sts_t sts_i,
  output ant_pkg::ctl_t      ctl_o
);
  import ant_pkg::*;
  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (start) state_d = S_SEARCH;
      S_SEARCH: begin
        case (sts_i.cmd)
          CmdUpsert: begin
            if (sts_i.hit) state_d = S_REPLY;
            else if (sts_i.walk_end) state_d = sts_i.full ? S_REPLY : S_APPEND;
          end
          CmdWrite:  state_d = S_REPLY;
          CmdExpire: state_d = sts_i.walk_end ? S_REPLY : S_SCAN;
          default:   state_d = S_READ;
        endcase
      end
      S_APPEND: state_d = S_CLEAR;
      S_CLEAR:  if (sts_i.nbr_last) state_d = S_REPLY;
      S_SCAN: begin
        if (!sts_i.expired && sts_i.moving) state_d = S_MOVE;
        else state_d = S_SEARCH;
      end
      S_MOVE:  if (sts_i.nbr_last) state_d = S_SEARCH;
      S_READ:  state_d = S_READ2;
      S_READ2: state_d = S_REPLY;
      S_REPLY: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Outputs. In S_SEARCH for upsert the meta of walk index minus one was
  // read in the previous cycle, and the datapath compares it in this cycle.
  always_comb begin
    ctl_o = '0;
    busy  = (state_q != S_IDLE);
    case (state_q)
      S_IDLE: begin
        ctl_o.latch   = start;
        ctl_o.idx_clr = start;
      end
      S_SEARCH: begin
        case (sts_i.cmd)
          CmdUpsert: begin
            if (sts_i.hit) begin
              ctl_o.set_hit = 1'b1;
              ctl_o.wr_meta_new = 1'b1;
              ctl_o.fin_up = 1'b1;
            end else if (sts_i.walk_end) begin
              if (sts_i.full) ctl_o.fin_full = 1'b1;
              else ctl_o.set_app = 1'b1;
            end else begin
              ctl_o.rd_meta = 1'b1;
              ctl_o.idx_inc = 1'b1;
            end
          end
          CmdWrite: ctl_o.wr_nbr_req = sts_i.wr_ok;
          CmdExpire: begin
            if (sts_i.walk_end) ctl_o.fin_exp = 1'b1;
            else ctl_o.rd_meta = 1'b1;
          end
          default: begin
            ctl_o.rd_meta  = 1'b1;
            ctl_o.rd_sel_e = 1'b1;
          end
        endcase
      end
      S_APPEND: begin
        ctl_o.wr_meta_new = 1'b1;
        ctl_o.fin_up      = 1'b1;
      end
      S_CLEAR: begin
        ctl_o.wr_nbr_clr = 1'b1;
        ctl_o.nbr_inc    = 1'b1;
      end
      S_SCAN: begin
        ctl_o.keep    = !sts_i.expired;
        ctl_o.drop    = sts_i.expired;
        ctl_o.mv_meta = !sts_i.expired && sts_i.moving;
        ctl_o.idx_inc = sts_i.expired || !sts_i.moving;
      end
      S_MOVE: begin
        ctl_o.mv_nbr  = 1'b1;
        ctl_o.nbr_inc = 1'b1;
        ctl_o.idx_inc = sts_i.nbr_last;
      end
      // Hold the read address so the record is still on the read ports.
      S_READ:  ctl_o.rd_sel_e = 1'b1;
      S_READ2: ctl_o.capture = 1'b1;
      S_REPLY: ctl_o.emit = 1'b1;
      default: ctl_o = '0;
    endcase
  end
endmodule
`default_nettype wire

[hdl/ant_dp.sv]
// Datapath of the aging node table: record memories, walk counters, result regs.
// Depends on ant_pkg and ant_ram.
`default_nettype none
module ant_dp (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic [7:0]    age_i,
  input  wire logic [1:0]    command_i,
  input  wire logic [15:0]   vertex_i,
  input  wire logic [4:0]    neighbor_count_i,
  input  wire logic [3:0]    neighbor_index_i,
  input  wire logic [15:0]   neighbor_id_i,
  input  wire logic [3:0]    entry_index_i,
  input  wire logic [31:0]   now_i,
  input  wire ant_pkg::ctl_t ctl_i,
  output ant_pkg::sts_t      sts_o,
  output logic               done_o,
  output logic [2:0]         status_o,
  output logic [3:0]         slot_o,
  output logic [4:0]         entry_count_o,
  output logic [4:0]         removed_count_o,
  output logic [15:0]        vertex_out_o,
  output logic [4:0]         count_out_o,
  output logic [15:0]        neighbor_out_o,
  output logic [31:0]        stamp_out_o
);
  import ant_pkg::*;

  // Request registers.
  logic [1:0]      cmd_q;
  logic [15:0]     vtx_q, nid_q;
  logic [NcW-1:0]  ncnt_q;
  logic [3:0]      nidx_q, eidx_q;
  logic [31:0]     now_q;

  // Control state.
  logic [CntW-1:0] used_q, used_d;
  logic [RecW-1:0] cur_q, cur_d;
  logic            curv_q, curv_d;
  logic            cur_kept_q;
  logic [RecW-1:0] cur_new_q;
  logic [CntW-1:0] walk_q, kept_q, rem_q;
  logic [NbrW:0]   nbr_q;
  logic [RecW-1:0] tgt_q;
  logic            rdv_q;

  // Memories.
  localparam int MetaW = 16 + NcW + 32;
  logic              meta_we;
  logic [RecW-1:0]   meta_wa, meta_ra;
  logic [MetaW-1:0]  meta_wd, meta_rd;
  logic              nbr_we;
  logic [NbrAw-1:0]  nbr_wa, nbr_ra;
  logic [15:0]       nbr_wd, nbr_rd;

  ant_ram #(.Width(MetaW), .Depth(MaxRecords)) u_meta (
    .clk_i, .we_i(meta_we), .waddr_i(meta_wa), .wdata_i(meta_wd),
    .raddr_i(meta_ra), .rdata_o(meta_rd)
  );
  ant_ram #(.Width(16), .Depth(MaxRecords * MaxNeighbors)) u_nbr (
    .clk_i, .we_i(nbr_we), .waddr_i(nbr_wa), .wdata_i(nbr_wd),
    .raddr_i(nbr_ra), .rdata_o(nbr_rd)
  );

  logic [15:0]    rd_vtx;
  logic [NcW-1:0] rd_cnt;
  logic [31:0]    rd_stamp;
  logic [32:0]    limit;
  assign {rd_vtx, rd_cnt, rd_stamp} = meta_rd;
  assign limit = {1'b0, rd_stamp} + {25'd0, age_i};

  logic [RecW-1:0] walk_a, kept_a;
  assign walk_a = walk_q[RecW-1:0];
  assign kept_a = kept_q[RecW-1:0];

  assign meta_ra = ctl_i.rd_sel_e ? eidx_q[RecW-1:0] : walk_a;
  // During a move the neighbor read runs one slot ahead of the write.
  assign nbr_ra = ctl_i.rd_sel_e ? {eidx_q[RecW-1:0], nidx_q[NbrW-1:0]}
                : {walk_a, (ctl_i.mv_nbr ? nbr_q[NbrW-1:0] + NbrW'(1) : NbrW'(0))};

  always_comb begin
    meta_we = 1'b0;
    meta_wa = tgt_q;
    meta_wd = {vtx_q, ncnt_q, now_q};
    if (ctl_i.wr_meta_new) begin
      meta_we = 1'b1;
      meta_wa = ctl_i.set_hit ? walk_a - RecW'(1) : tgt_q;
      meta_wd = {(ctl_i.set_hit ? rd_vtx : vtx_q), ncnt_q, now_q};
    end else if (ctl_i.mv_meta) begin
      meta_we = 1'b1;
      meta_wa = kept_a;
      meta_wd = meta_rd;
    end
  end

  always_comb begin
    nbr_we = 1'b0;
    nbr_wa = {tgt_q, nbr_q[NbrW-1:0]};
    nbr_wd = 16'd0;
    if (ctl_i.wr_nbr_clr) begin
      nbr_we = 1'b1;
    end else if (ctl_i.wr_nbr_req) begin
      nbr_we = 1'b1;
      nbr_wa = {cur_q, nidx_q[NbrW-1:0]};
      nbr_wd = nid_q;
    end else if (ctl_i.mv_nbr) begin
      nbr_we = 1'b1;
      nbr_wa = {kept_a, nbr_q[NbrW-1:0]};
      nbr_wd = nbr_rd;
    end
  end

  // Status toward the controller. The upsert compare works on the record
  // read last cycle, which sits at walk index minus one.
  always_comb begin
    sts_o          = '0;
    sts_o.cmd      = cmd_q;
    sts_o.walk_end = (walk_q == used_q);
    sts_o.hit      = rdv_q && (rd_vtx == vtx_q);
    sts_o.full     = (used_q == CntW'(MaxRecords));
    sts_o.expired  = ({1'b0, now_q} > limit);
    sts_o.moving   = (kept_q != walk_q);
    sts_o.nbr_last = (nbr_q[NbrW-1:0] == NbrW'(MaxNeighbors - 1));
    sts_o.wr_ok    = curv_q && ({1'b0, cur_q} < used_q)
                     && (nidx_q < 5'(MaxNeighbors));
    sts_o.rd_ok    = ({1'b0, eidx_q} < used_q) && (nidx_q < 5'(MaxNeighbors));
  end

  always_comb begin
    used_d = used_q;
    cur_d  = cur_q;
    curv_d = curv_q;
    if (ctl_i.fin_up) begin
      cur_d  = ctl_i.set_hit ? walk_a - RecW'(1) : tgt_q;
      curv_d = 1'b1;
      if (!ctl_i.set_hit) used_d = used_q + CntW'(1);
    end
    if (ctl_i.fin_full) curv_d = 1'b0;
    if (ctl_i.fin_exp) begin
      used_d = kept_q;
      if (curv_q) begin
        curv_d = cur_kept_q;
        if (cur_kept_q) cur_d = cur_new_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
      cur_q  <= '0;
      curv_q <= 1'b0;
      walk_q <= '0;
      kept_q <= '0;
      rem_q  <= '0;
      nbr_q  <= '0;
      rdv_q  <= 1'b0;
      cur_kept_q <= 1'b0;
      cur_new_q  <= '0;
      tgt_q  <= '0;
      done_o <= 1'b0;
    end else begin
      used_q <= used_d;
      cur_q  <= cur_d;
      curv_q <= curv_d;
      done_o <= ctl_i.emit;
      if (ctl_i.idx_clr) begin
        walk_q <= '0;
        kept_q <= '0;
        rem_q  <= '0;
        nbr_q  <= '0;
        rdv_q  <= 1'b0;
        cur_kept_q <= 1'b0;
      end else begin
        if (ctl_i.idx_inc) walk_q <= walk_q + CntW'(1);
        if (ctl_i.nbr_inc) nbr_q <= sts_o.nbr_last ? '0 : nbr_q + 1'b1;
        rdv_q <= ctl_i.rd_meta && (cmd_q == CmdUpsert);
        if (ctl_i.keep) begin
          if (curv_q && (cur_q == walk_a)) begin
            cur_kept_q <= 1'b1;
            cur_new_q  <= kept_a;
          end
        end
        if (ctl_i.keep && !ctl_i.mv_meta) kept_q <= kept_q + CntW'(1);
        if (ctl_i.mv_nbr && sts_o.nbr_last) kept_q <= kept_q + CntW'(1);
        if (ctl_i.drop) rem_q <= rem_q + CntW'(1);
        if (ctl_i.set_app) tgt_q <= used_q[RecW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.latch) begin
      cmd_q  <= command_i;
      vtx_q  <= vertex_i;
      ncnt_q <= (neighbor_count_i > 5'(MaxNeighbors)) ? NcW'(MaxNeighbors)
                                                     : neighbor_count_i[NcW-1:0];
      nidx_q <= neighbor_index_i;
      nid_q  <= neighbor_id_i;
      eidx_q <= entry_index_i;
      now_q  <= now_i;
    end
    if (ctl_i.capture) begin
      status_o        <= sts_o.rd_ok ? StDone : StBadIndex;
      vertex_out_o    <= sts_o.rd_ok ? rd_vtx : '0;
      count_out_o     <= sts_o.rd_ok ? 5'(rd_cnt) : '0;
      neighbor_out_o  <= sts_o.rd_ok ? nbr_rd : '0;
      stamp_out_o     <= sts_o.rd_ok ? rd_stamp : '0;
      slot_o          <= '0;
      removed_count_o <= '0;
    end
    if (ctl_i.fin_up || ctl_i.fin_full) begin
      status_o <= ctl_i.fin_full ? StFull : (ctl_i.set_hit ? StUpdated : StInserted);
      slot_o   <= ctl_i.fin_full ? '0 : (ctl_i.set_hit ? walk_a - RecW'(1) : tgt_q);
      removed_count_o <= '0;
      {vertex_out_o, count_out_o, neighbor_out_o, stamp_out_o} <= '0;
    end
    if (ctl_i.fin_exp) begin
      status_o <= StDone;
      slot_o   <= '0;
      removed_count_o <= rem_q;
      {vertex_out_o, count_out_o, neighbor_out_o, stamp_out_o} <= '0;
    end
    if (ctl_i.latch && command_i == CmdWrite) begin
      {vertex_out_o, count_out_o, neighbor_out_o, stamp_out_o} <= '0;
      removed_count_o <= '0;
    end
    if (cmd_q == CmdWrite && !ctl_i.latch && !ctl_i.emit) begin
      status_o <= sts_o.wr_ok ? StUpdated : StBadIndex;
      slot_o   <= sts_o.wr_ok ? cur_q : '0;
    end
  end
  assign entry_count_o = used_q;
endmodule
`default_nettype wire

[hdl/aging_node_table_unit.sv]
// Top level of the aging node table: controller, datapath, expiry register.
// Depends on ant_pkg, ant_ctrl, ant_dp and ant_ram.
`default_nettype none
// A request is taken when start is high and busy is low; exactly one
// result follows, shown for one cycle with done_o high, and the receiver
// cannot stall it. A neighbor write passes through the search and reply
// states; a read passes through search, two read states and reply. An upsert
// walks the table one record a cycle until a hit or the end of the table;
// a table that is full then reports StFull. An append then clears the new
// record's 16-word neighbor row in the neighbor memory, which has one write
// port. An expire scans each record once, and the neighbor row of each record
// that moves down is copied one word a cycle. A new request may be taken in
// the cycle that shows the result.
// expiry_age is written through cfg_valid_i/cfg_ready_o, which is always ready;
// write it only while idle.
module aging_node_table_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [7:0]  cfg_data_i,
  input  wire logic [1:0]  command_i,
  input  wire logic [15:0] vertex_i,
  input  wire logic [4:0]  neighbor_count_i,
  input  wire logic [3:0]  neighbor_index_i,
  input  wire logic [15:0] neighbor_id_i,
  input  wire logic [3:0]  entry_index_i,
  input  wire logic [31:0] now_i,
  output logic             done_o,
  output logic [2:0]       status_o,
  output logic [3:0]       slot_o,
  output logic [4:0]       entry_count_o,
  output logic [4:0]       removed_count_o,
  output logic [15:0]      vertex_out_o,
  output logic [4:0]       count_out_o,
  output logic [15:0]      neighbor_out_o,
  output logic [31:0]      stamp_out_o
);
  import ant_pkg::*;
  logic [7:0] age_q;
  ctl_t ctl;
  sts_t sts;

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) age_q <= 8'd5;
    else if (cfg_valid_i) age_q <= cfg_data_i;
  end

  ant_ctrl u_ctrl (.clk_i, .rst_ni, .start, .busy, .sts_i(sts), .ctl_o(ctl));
  ant_dp u_dp (
    .clk_i, .rst_ni, .age_i(age_q), .command_i, .vertex_i, .neighbor_count_i,
    .neighbor_index_i, .neighbor_id_i, .entry_index_i, .now_i, .ctl_i(ctl),
    .sts_o(sts), .done_o, .status_o, .slot_o, .entry_count_o, .removed_count_o,
    .vertex_out_o, .count_out_o, .neighbor_out_o, .stamp_out_o
  );

`ifndef SYNTHESIS
  // A result strobe only ever closes a request.
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy)) else $error("result without request");
  // The table never holds more than its capacity.
  a_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    entry_count_o <= 5'(MaxRecords)) else $error("table overfilled");
  // An accepted request (start high while idle) always raises busy.
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("request not taken");
`endif
endmodule
`default_nettype wire
